>>> rtl/grbp_pkg.sv
package grbp_pkg;

	localparam int BYTE_BITS = 8;

	// Packer state after reset and after the flush on the last pixel.
	localparam logic [7:0] PENDING_RESET = 8'd0;
	localparam logic [3:0] FREE_RESET    = 4'd8;

	typedef struct packed {
		logic [7:0] pending;
		logic [3:0] free;
	} pack_state_t;

	// One output byte with its final-byte flag.
	typedef struct packed {
		logic       final_byte;
		logic [7:0] packed_byte;
	} out_item_t;

	// Bytes produced by one pixel, in delivery order: item0 first.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  item0;
		out_item_t  item1;
	} pack_result_t;

endpackage

>>> rtl/gray_requantize_bit_packer_unit.sv
// Gray requantizing bit packer. Each pixel transaction on s_axis is scaled to
// floor(pixel * max_gray_level / 255) and packed MSB first into bytes of
// floor(log2(max_gray_level)) + 1 bit codes; the pixel marked by tlast flushes
// the partial byte, sent with m_axis_tlast high, and restarts the packing.
// One pixel is accepted every clock cycle: it is captured in an input register
// and then scaled and packed into a four-entry output queue. The output delivers
// one byte per cycle while m_axis_tready is high; the input stalls only while the
// queue holds more than two bytes, which happens when m_axis is held off.
// max_gray_level is written through cfg_valid/cfg_data and is always ready;
// write it only between images or while the block is empty.
module gray_requantize_bit_packer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,      // max_gray_level
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] pixel
	input  logic       s_axis_tlast,  // last_pixel
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] packed_byte
	output logic       m_axis_tlast   // final_byte
);

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);

	logic [6:0]             max_q;
	logic                   valid_s1;
	logic [7:0]             pixel_s1;
	logic                   last_s1;
	grbp_pkg::pack_state_t  state_q;
	grbp_pkg::pack_state_t  state_nxt;
	grbp_pkg::pack_result_t result;
	grbp_pkg::out_item_t    queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;
	logic                   advance;
	logic                   pop;
	logic [1:0]             push_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 7'd127;
		end else if (cfg_valid) begin
			max_q <= cfg_data;
		end
	end

	// The stage hands its pixel on only when the queue can take two bytes.
	assign advance       = valid_s1 && (count_q <= (PTR_W+1)'(QUEUE_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pixel_s1 <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
		end
	end

	grbp_pack u_pack (
		.pixel          (pixel_s1),
		.last_pixel     (last_s1),
		.max_gray_level (max_q),
		.state_cur      (state_q),
		.state_nxt      (state_nxt),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pending <= grbp_pkg::PENDING_RESET;
			state_q.free    <= grbp_pkg::FREE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign push_n = advance ? result.count : 2'd0;
	assign pop    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= result.item0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= result.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
		end
	end

	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = queue_q[rd_ptr_q].packed_byte;
	assign m_axis_tlast  = queue_q[rd_ptr_q].final_byte;

endmodule

>>> rtl/grbp_pack.sv
module grbp_pack (
	input  logic [7:0]            pixel,
	input  logic                  last_pixel,
	input  logic [6:0]            max_gray_level,
	input  grbp_pkg::pack_state_t state_cur,
	output grbp_pkg::pack_state_t state_nxt,
	output grbp_pkg::pack_result_t result
);

	logic [14:0] product;
	logic [14:0] quot_sum;
	logic [6:0]  code;
	logic [3:0]  width;
	logic [3:0]  spill;
	logic [3:0]  free_after;
	logic [7:0]  pend_after;
	logic        spilled;
	logic [7:0]  spill_byte;
	logic [15:0] code_ext;

	always_comb begin
		priority if (max_gray_level[6]) width = 4'd7;
		else if (max_gray_level[5]) width = 4'd6;
		else if (max_gray_level[4]) width = 4'd5;
		else if (max_gray_level[3]) width = 4'd4;
		else if (max_gray_level[2]) width = 4'd3;
		else if (max_gray_level[1]) width = 4'd2;
		else width = 4'd1;
	end

	// Division by 255 for a 15-bit value: (x + (x >> 8) + 1) >> 8 is exact here.
	assign product  = 15'(pixel) * 15'(max_gray_level);
	assign quot_sum = product + 15'(product[14:8]) + 15'd1;
	assign code     = quot_sum[14:8];
	assign code_ext = {9'd0, code};

	assign spilled = state_cur.free < width;
	assign spill   = width - state_cur.free;

	always_comb begin
		if (spilled) begin
			spill_byte = state_cur.pending | 8'(code >> spill);
			free_after = 4'(grbp_pkg::BYTE_BITS) - spill;
		end else begin
			spill_byte = state_cur.pending;
			free_after = state_cur.free - width;
		end
		if (spilled) begin
			pend_after = code_ext[7:0] << free_after;
		end else begin
			pend_after = state_cur.pending | 8'(code_ext << free_after);
		end
	end

	always_comb begin
		result = '0;
		if (last_pixel) begin
			state_nxt.pending = grbp_pkg::PENDING_RESET;
			state_nxt.free    = grbp_pkg::FREE_RESET;
		end else begin
			state_nxt.pending = pend_after;
			state_nxt.free    = free_after;
		end
		// At least one bit is always pending after a code, so the last pixel
		// always flushes a byte.
		if (spilled) begin
			result.item0.packed_byte = spill_byte;
			result.item0.final_byte  = 1'b0;
			result.item1.packed_byte = pend_after;
			result.item1.final_byte  = 1'b1;
			result.count             = last_pixel ? 2'd2 : 2'd1;
		end else begin
			result.item0.packed_byte = pend_after;
			result.item0.final_byte  = 1'b1;
			result.count             = last_pixel ? 2'd1 : 2'd0;
		end
	end

endmodule
